// ===== sv/rbbea_pkg.sv =====
// Package for the RGB box blur: widths, limits and the request code.
// No dependencies.
package rbbea_pkg;
  localparam int RadiusDefault   = 1;
  localparam int MaxWidthDefault = 1024;
  localparam int MaxHeight       = 4096;
  localparam int HeightBits      = 13;
  localparam int WidthBits       = 11;
  localparam int PixBits         = 24;
  localparam logic ReqPixel      = 1'b0;
  localparam logic ReqFlush      = 1'b1;
  localparam logic CfgHeight     = 1'b0;
  localparam logic CfgWidth      = 1'b1;
endpackage

// ===== sv/rgb_box_blur_edge_average.sv =====
// Top level of the RGB box blur: line ring memory, window sequencer, output register.
// Depends on rbbea_pkg and rbbea_div.
//
// Pixels enter on req_valid/req_ready with req_type, red_in, green_in, blue_in.
// Results leave on res_valid/res_ready with red_out, green_out, blue_out and
// frame_end. Frame size is written on cfg_valid/cfg_ready (index 0 height,
// index 1 width) and is latched at the first pixel of a frame.
// Each beat is handled alone and its payload is held in a register. A beat that
// causes a result reads the window from the ring memory, one pixel per cycle,
// and waits for the last reads. Three serial divides follow, one per colour
// channel, over a sum that is 12 bits wide with R = 1. No new beat is taken
// while one is in progress; a beat with no result returns straight to idle.
// The ring read port and the divider set the item time. Reset clears
// counters and size to one by one; the ring holds no reset value and is
// written before it is read. A stalled receiver holds the result in the
// output register and the next beat is not taken until it leaves.
module rgb_box_blur_edge_average import rbbea_pkg::*; #(
  parameter int RADIUS    = RadiusDefault,
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic                  req_type,
  input  logic [7:0]            red_in,
  input  logic [7:0]            green_in,
  input  logic [7:0]            blue_in,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [7:0]            red_out,
  output logic [7:0]            green_out,
  output logic [7:0]            blue_out,
  output logic                  frame_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [HeightBits-1:0] cfg_data
);
  localparam int Win      = 2 * RADIUS + 1;
  localparam int RingSize = 2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 1;
  localparam int AddrBits = $clog2(RingSize);
  localparam int WBits    = $clog2(MAX_WIDTH + 1);
  localparam int CBits    = $clog2(MAX_WIDTH);
  localparam int RBits    = $clog2(MaxHeight);
  localparam int HBits    = $clog2(MaxHeight + 1);
  localparam int CntBits  = $clog2(Win * Win + 1);
  localparam int SumBits  = 8 + CntBits;
  localparam int WinBits  = $clog2(Win + 1);
  localparam int PosBits  = RBits + CBits + 1;
  localparam int DlyBits  = PosBits + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_ACCEPT, S_READ, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic [PixBits-1:0] ring [RingSize];
  logic [PixBits-1:0] rd_data;
  logic [AddrBits-1:0] wr_ptr, in_ptr, rd_addr;
  logic [HeightBits-1:0] reg_height;
  logic [WidthBits-1:0]  reg_width;
  logic [HBits-1:0] act_h;
  logic [WBits-1:0] act_w;
  logic [RBits-1:0] in_row, out_row;
  logic [CBits-1:0] in_col, out_col;
  logic in_done;
  logic [PosBits-1:0] recv_cnt, sent_cnt;
  logic [AddrBits-1:0] out_ptr;
  logic [WinBits-1:0] wa, wb;
  logic rd_pend;
  logic rd_ok;
  logic kind;
  logic [PixBits-1:0] pix;
  logic [SumBits-1:0] sr, sg, sb;
  logic [CntBits-1:0] n;
  logic [1:0] ch;
  logic div_start, div_done;
  logic [7:0] quo;
  logic [SumBits-1:0] div_num;
  logic last;
  logic [HBits-1:0] h_sat;
  logic [WBits-1:0] w_sat;
  logic signed [RBits+1:0] rr;
  logic signed [CBits+1:0] cc;
  logic in_frame;
  logic signed [AddrBits+1:0] offs, raddr_s;
  logic [DlyBits-1:0] delay;

  assign cfg_ready = (state == S_IDLE);
  assign req_ready = (state == S_IDLE) && !res_valid;

  always_comb begin
    if (reg_height == '0) h_sat = HBits'(1);
    else if ({1'b0, reg_height} > (HeightBits+1)'(MaxHeight)) h_sat = HBits'(MaxHeight);
    else h_sat = HBits'(reg_height);
    if (reg_width == '0) w_sat = WBits'(1);
    else if (32'(reg_width) > 32'(MAX_WIDTH)) w_sat = WBits'(MAX_WIDTH);
    else w_sat = WBits'(reg_width);
  end

  // Window position relative to the output pixel.
  always_comb begin
    rr = $signed({2'b0, out_row}) + $signed((RBits+2)'(wa)) - $signed((RBits+2)'(RADIUS));
    cc = $signed({2'b0, out_col}) + $signed((CBits+2)'(wb)) - $signed((CBits+2)'(RADIUS));
    in_frame = (rr >= 0) && (rr < $signed((RBits+2)'(act_h)))
            && (cc >= 0) && (cc < $signed((CBits+2)'(act_w)));
    offs = $signed((AddrBits+2)'(rr - $signed({2'b0, out_row}))) * $signed({2'b0, act_w})
         + $signed((AddrBits+2)'(cc - $signed({2'b0, out_col})));
    raddr_s = $signed({2'b0, out_ptr}) + offs;
    if (raddr_s < 0) raddr_s = raddr_s + (AddrBits+2)'(RingSize);
    else if (raddr_s >= $signed((AddrBits+2)'(RingSize)))
      raddr_s = raddr_s - (AddrBits+2)'(RingSize);
    delay = DlyBits'(RADIUS) * DlyBits'(act_w) + DlyBits'(RADIUS);
    last = (HBits'(out_row) == act_h - 1'b1) && (WBits'(out_col) == act_w - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (state == S_ACCEPT && !in_done && kind == ReqPixel) begin
      ring[in_ptr] <= pix;
    end
    rd_data <= ring[rd_addr];
  end

  always_comb begin
    case (ch)
      2'd0:    div_num = sr;
      2'd1:    div_num = sg;
      default: div_num = sb;
    endcase
  end

  rbbea_div #(.SumBits(SumBits), .CntBits(CntBits)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(n), .done(div_done), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      reg_height <= HeightBits'(1);
      reg_width <= WidthBits'(1);
      act_h <= HBits'(1);
      act_w <= WBits'(1);
      in_row <= '0; in_col <= '0; out_row <= '0; out_col <= '0;
      in_done <= 1'b0;
      recv_cnt <= '0; sent_cnt <= '0;
      wr_ptr <= '0; out_ptr <= '0;
      res_valid <= 1'b0;
      div_start <= 1'b0;
      rd_pend <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CfgHeight) reg_height <= cfg_data;
            else reg_width <= cfg_data[WidthBits-1:0];
          end
          if (req_valid && req_ready) begin
            in_ptr <= wr_ptr;
            kind <= req_type;
            pix <= {red_in, green_in, blue_in};
            state <= S_ACCEPT;
            if (!in_done && req_type == ReqPixel && in_row == '0 && in_col == '0) begin
              act_h <= h_sat;
              act_w <= w_sat;
            end
          end
        end
        S_ACCEPT: begin
          if (!in_done && kind == ReqFlush) begin
            state <= S_IDLE;
          end else if (in_done) begin
            state <= S_READ;
          end else begin
            wr_ptr <= (32'(wr_ptr) == RingSize - 1) ? '0 : wr_ptr + 1'b1;
            recv_cnt <= recv_cnt + 1'b1;
            if (WBits'(in_col) == act_w - 1'b1) begin
              in_col <= '0;
              in_row <= in_row + 1'b1;
              if (HBits'(in_row) == act_h - 1'b1) in_done <= 1'b1;
            end else begin
              in_col <= in_col + 1'b1;
            end
            if (DlyBits'(recv_cnt + 1'b1 - sent_cnt) > delay)
              state <= S_READ;
            else state <= S_IDLE;
          end
          wa <= '0; wb <= '0; rd_pend <= 1'b0; rd_ok <= 1'b0;
          sr <= '0; sg <= '0; sb <= '0; n <= '0;
        end
        S_READ: begin
          if (rd_ok) begin
            sr <= sr + SumBits'(rd_data[23:16]);
            sg <= sg + SumBits'(rd_data[15:8]);
            sb <= sb + SumBits'(rd_data[7:0]);
            n  <= n + 1'b1;
          end
          rd_ok <= rd_pend;
          rd_pend <= 1'b0;
          if (wa == WinBits'(Win)) begin
            if (!rd_pend && !rd_ok) begin
              if (n == '0) n <= CntBits'(1);
              ch <= 2'd0;
              div_start <= 1'b1;
              state <= S_DIV;
            end
          end else begin
            if (in_frame) begin
              rd_addr <= AddrBits'(raddr_s);
              rd_pend <= 1'b1;
            end
            if (wb == WinBits'(Win - 1)) begin
              wb <= '0; wa <= wa + 1'b1;
            end else begin
              wb <= wb + 1'b1;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            case (ch)
              2'd0: red_out <= quo;
              2'd1: green_out <= quo;
              default: blue_out <= quo;
            endcase
            if (ch == 2'd2) state <= S_OUT;
            else begin
              ch <= ch + 1'b1;
              div_start <= 1'b1;
            end
          end
        end
        S_OUT: begin
          res_valid <= 1'b1;
          frame_end <= last;
          state <= S_IDLE;
          if (last) begin
            in_row <= '0; in_col <= '0; out_row <= '0; out_col <= '0;
            in_done <= 1'b0; recv_cnt <= '0; sent_cnt <= '0;
            wr_ptr <= '0; out_ptr <= '0;
          end else begin
            sent_cnt <= sent_cnt + 1'b1;
            out_ptr <= (32'(out_ptr) == RingSize - 1) ? '0 : out_ptr + 1'b1;
            if (WBits'(out_col) == act_w - 1'b1) begin
              out_col <= '0; out_row <= out_row + 1'b1;
            end else out_col <= out_col + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !res_valid) else $error("ready while result pending");
  a_sent_le_recv: assert property (@(posedge clk) disable iff (rst)
    sent_cnt <= recv_cnt) else $error("output ahead of input");
  a_out_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_OUT)) else $error("result without window");
endmodule

// ===== sv/rbbea_div.sv =====
// Sequential restoring divider for one pixel sum over up to 2^CntBits - 1 samples.
// Depends on rbbea_pkg.
module rbbea_div import rbbea_pkg::*; #(
  parameter int SumBits = 14,
  parameter int CntBits = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SumBits-1:0] num,
  input  logic [CntBits-1:0] den,
  output logic               done,
  output logic [7:0]         quo
);
  localparam int StepBits = $clog2(SumBits + 1);
  logic [SumBits-1:0] q;
  logic [CntBits:0]   r;
  logic [CntBits-1:0] d;
  logic [StepBits-1:0] step;
  logic busy;
  logic [CntBits:0] r_sh;

  always_comb begin
    r_sh = {r[CntBits-1:0], q[SumBits-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        d    <= den;
        r    <= '0;
        step <= StepBits'(SumBits);
      end else if (busy) begin
        if (r_sh >= {1'b0, d}) begin
          r <= r_sh - {1'b0, d};
          q <= {q[SumBits-2:0], 1'b1};
        end else begin
          r <= r_sh;
          q <= {q[SumBits-2:0], 1'b0};
        end
        step <= step - 1'b1;
        if (step == StepBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q[7:0];
endmodule
